FILE: sv/utf8_glyph_lookup_caret_defines.svh
// assertion macros used by the checker file
`ifndef UTF8_GLYPH_LOOKUP_CARET_DEFINES_SVH
`define UTF8_GLYPH_LOOKUP_CARET_DEFINES_SVH

// clocked assertion, switched off while reset is high
`define UGL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// clocked assertion that also holds through reset
`define UGL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: sv/ugl_pkg.sv
// types and constants for the utf-8 glyph lookup block
package ugl_pkg;

  localparam int TABLE_SLOTS_DEF = 128;

  localparam int CODE_W    = 16;
  localparam int ADV_W     = 8;
  localparam int CARET_W   = 24;
  localparam int SLOT_W    = 7;
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 8;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;

  localparam logic             KIND_LOAD = 1'b0;
  localparam logic             KIND_TEXT = 1'b1;
  localparam logic [CODE_W-1:0]  BAD_CODE  = 16'hFFFF;
  localparam logic [CARET_W-1:0] CARET_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [CODE_W-1:0] code;
  } scan_req_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [ADV_W-1:0]  advance;
  } scan_rsp_t;

endpackage

FILE: sv/ugl_scan.sv
// glyph table memory and the single comparator that sweeps it for the first match
module ugl_scan #(
  parameter int TABLE_SLOTS = ugl_pkg::TABLE_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [ugl_pkg::SLOT_W-1:0]  wr_slot,
  input  logic [ugl_pkg::CODE_W-1:0]  wr_code,
  input  logic [ugl_pkg::ADV_W-1:0]   wr_adv,
  input  logic [ugl_pkg::CFG_W-1:0]   glyphs_in_use,
  input  ugl_pkg::scan_req_t          req,
  output ugl_pkg::scan_rsp_t          rsp
);
  import ugl_pkg::*;

  localparam int ADDR_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int ENT_W  = CODE_W + ADV_W;

  logic [ENT_W-1:0]  mem [TABLE_SLOTS];
  logic [ENT_W-1:0]  rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_valid;
  logic              active;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  limit;
  logic [CODE_W-1:0] code;
  logic              done;
  logic              found;
  logic [ADDR_W-1:0] hit_slot;
  logic [ADV_W-1:0]  hit_adv;

  logic [31:0]       wr_wide;
  logic              wr_ok;
  logic [CNT_W-1:0]  limit_calc;
  logic              hit_now;
  logic              miss_now;
  logic              rd_en;
  logic [31:0]       slot_wide;

  assign wr_wide = 32'(wr_slot);
  assign wr_ok   = wr_wide < 32'(TABLE_SLOTS);

  // search length clamps to the table depth
  assign limit_calc = (32'(glyphs_in_use) > 32'(TABLE_SLOTS)) ?
                      CNT_W'(TABLE_SLOTS) : CNT_W'(glyphs_in_use);

  assign hit_now  = active && rd_valid && (rd_data[ENT_W-1:ADV_W] == code);
  assign miss_now = active && !rd_valid && (idx >= limit);
  assign rd_en    = active && !req.start && (idx < limit) && !hit_now;

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_wide[ADDR_W-1:0]] <= {wr_code, wr_adv};
    end
    if (rd_en) begin
      rd_data <= mem[idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active   <= 1'b1;
        rd_valid <= 1'b0;
      end else if (hit_now || miss_now) begin
        active   <= 1'b0;
        rd_valid <= 1'b0;
        done     <= 1'b1;
      end else begin
        rd_valid <= rd_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      idx   <= '0;
      limit <= limit_calc;
      code  <= req.code;
    end else if (rd_en) begin
      idx <= idx + CNT_W'(1);
    end
    if (rd_en) begin
      rd_addr <= idx[ADDR_W-1:0];
    end
    if (hit_now) begin
      found    <= 1'b1;
      hit_slot <= rd_addr;
      hit_adv  <= rd_data[ADV_W-1:0];
    end else if (miss_now) begin
      found    <= 1'b0;
      hit_slot <= '0;
      hit_adv  <= '0;
    end
  end

  assign slot_wide   = 32'(hit_slot);
  assign rsp.done    = done;
  assign rsp.found   = found;
  assign rsp.slot    = slot_wide[SLOT_W-1:0];
  assign rsp.advance = hit_adv;

endmodule

FILE: sv/utf8_glyph_lookup_caret.sv
// top level: utf-8 decoder, glyph table search sequencer and caret tracking
//
// Load words (tuser 0) write one glyph table slot. Text words (tuser 1) carry
// one utf-8 byte each; a byte that finishes a sequence, is no valid lead byte
// or ends the string early starts a search of the first glyphs_in_use slots
// (at most TABLE_SLOTS). The search uses one comparator fed by the table
// memory's single registered read port, one slot per cycle, stopping at the
// first match; such a word keeps the input busy until the search is done and
// its result is loaded, which waits for the output register to drain. The
// table needs no clearing after reset; slots must be loaded before a search
// covers them.
module utf8_glyph_lookup_caret #(
  parameter int TABLE_SLOTS = ugl_pkg::TABLE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // slot[6:0], entry_codepoint[22:7], entry_advance[30:23], text_byte[38:31], pad
  input  logic [ugl_pkg::S_TDATA_W-1:0] s_tdata,
  // kind
  input  logic                          s_tuser,
  // last_byte
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // codepoint[15:0], found[16], glyph_slot[23:17], caret[47:24]
  output logic [ugl_pkg::M_TDATA_W-1:0] m_tdata,
  // string_end
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [ugl_pkg::CFG_W-1:0]     cfg_wdata
);
  import ugl_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [CFG_W-1:0]   glyphs_in_use;
  logic [CARET_W-1:0] caret;
  logic [CARET_W-1:0] caret_next;
  logic [2:0]         bytes_expected;
  logic [2:0]         bytes_seen;
  logic [CODE_W-1:0]  partial_code;
  logic               sequence_bad;
  logic [CODE_W-1:0]  pend_code;
  logic               pend_end;

  logic [2:0]         exp_next;
  logic [2:0]         seen_next;
  logic [CODE_W-1:0]  part_next;
  logic               bad_next;
  logic               dec_emit;
  logic [CODE_W-1:0]  dec_code;

  logic               in_acc;
  logic               text_acc;
  logic               load_acc;
  logic               out_load;
  logic [BYTE_W-1:0]  b;
  logic [CARET_W:0]   caret_sum;

  scan_req_t          req;
  scan_rsp_t          rsp;

  assign in_acc   = s_tvalid && s_tready;
  assign text_acc = in_acc && (s_tuser == KIND_TEXT);
  assign load_acc = in_acc && (s_tuser == KIND_LOAD);
  assign b        = s_tdata[38:31];

  ugl_scan #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (load_acc),
    .wr_slot      (s_tdata[6:0]),
    .wr_code      (s_tdata[22:7]),
    .wr_adv       (s_tdata[30:23]),
    .glyphs_in_use(glyphs_in_use),
    .req          (req),
    .rsp          (rsp)
  );

  // byte decoder
  always_comb begin
    logic        bad_c;
    logic [CODE_W-1:0] part_c;
    logic [2:0]  seen_c;
    exp_next  = bytes_expected;
    seen_next = bytes_seen;
    part_next = partial_code;
    bad_next  = sequence_bad;
    dec_emit  = 1'b0;
    dec_code  = BAD_CODE;
    bad_c     = sequence_bad || (b[7:6] != 2'b10);
    part_c    = {partial_code[9:0], b[5:0]};
    seen_c    = bytes_seen + 3'd1;
    if (bytes_seen == 3'd0) begin
      if (!b[7]) begin
        dec_emit = 1'b1;
        dec_code = {8'h00, b};
      end else if (b[7:5] == 3'b110) begin
        exp_next  = 3'd2;
        part_next = {11'd0, b[4:0]};
        seen_next = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
        exp_next  = 3'd3;
        part_next = {12'd0, b[3:0]};
        seen_next = 3'd1;
      end else if (b[7:3] == 5'b11110) begin
        // four-byte lead: consumed but always bad
        exp_next  = 3'd4;
        part_next = '0;
        bad_next  = 1'b1;
        seen_next = 3'd1;
      end else begin
        dec_emit = 1'b1;
      end
      if (!dec_emit && s_tlast) begin
        dec_emit = 1'b1;
      end
    end else begin
      bad_next  = bad_c;
      part_next = part_c;
      seen_next = seen_c;
      if (seen_c >= bytes_expected) begin
        dec_emit = 1'b1;
        dec_code = bad_c ? BAD_CODE : part_c;
      end else if (s_tlast) begin
        dec_emit = 1'b1;
      end
    end
    if (dec_emit) begin
      exp_next  = '0;
      seen_next = '0;
      part_next = '0;
      bad_next  = 1'b0;
    end
  end

  assign req.start = text_acc && dec_emit;
  assign req.code  = dec_code;

  // caret moves by the matched glyph's advance, saturating, and clears at string end
  assign caret_sum = {1'b0, caret} + (CARET_W + 1)'(rsp.advance);
  always_comb begin
    caret_next = caret;
    if (rsp.found) begin
      caret_next = caret_sum[CARET_W] ? CARET_MAX : caret_sum[CARET_W-1:0];
    end
    if (pend_end) begin
      caret_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (req.start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyphs_in_use  <= '0;
      caret          <= '0;
      bytes_expected <= '0;
      bytes_seen     <= '0;
      partial_code   <= '0;
      sequence_bad   <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        glyphs_in_use <= cfg_wdata;
      end
      if (text_acc) begin
        bytes_expected <= exp_next;
        bytes_seen     <= seen_next;
        partial_code   <= part_next;
        sequence_bad   <= bad_next;
      end
      if (out_load) begin
        caret    <= caret_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      pend_code <= dec_code;
      pend_end  <= s_tlast;
    end
    if (out_load) begin
      m_tdata <= {caret, rsp.slot, rsp.found, pend_code};
      m_tlast <= pend_end;
    end
  end

endmodule

FILE: sv/ugl_checker.sv
// port-level checks for the utf-8 glyph lookup block, bound to the top level
`include "utf8_glyph_lookup_caret_defines.svh"

module ugl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [ugl_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                          s_tuser,
  input logic                          s_tlast,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ugl_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tlast
);
  import ugl_pkg::*;

  // a stalled result word holds
  `UGL_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result word changed while stalled")

  // the last byte of a string always gives a result, so the search keeps the input busy
  `UGL_ASSERT(a_last_busy, clk, rst, s_tvalid && s_tready && (s_tuser == KIND_TEXT) && s_tlast |=> !s_tready, "input still ready after the last byte of a string")

  // a table load never starts a search
  `UGL_ASSERT(a_load_idle, clk, rst, s_tvalid && s_tready && (s_tuser == KIND_LOAD) |=> s_tready, "input went busy after a table load")

  // a miss reports slot zero
  `UGL_ASSERT(a_miss_slot, clk, rst, m_tvalid && !m_tdata[16] |-> (m_tdata[23:17] == 7'd0), "nonzero slot on a miss")

  // nothing is offered right after reset
  `UGL_ASSERT_ALWAYS(a_reset_quiet, clk, $past(rst) |-> !m_tvalid, "result valid straight after reset")

endmodule

bind utf8_glyph_lookup_caret ugl_checker u_ugl_checker (.*);

FILE: bench/tb_utf8_glyph_lookup_caret.sv
// testbench for the utf-8 glyph lookup block: directed and random text against a local predictor
`timescale 1ns / 100ps

module tb_utf8_glyph_lookup_caret;
  import ugl_pkg::*;

  localparam int  QUIET_CYCLES = TABLE_SLOTS_DEF + 16;
  localparam int  DRAIN_LIMIT  = 50000;
  localparam int  HOLD_CYCLES  = 3000;
  localparam int  LONG_GLYPHS  = 20;

  typedef struct packed {
    logic [CODE_W-1:0]  codepoint;
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic [CARET_W-1:0] caret;
    logic               ends;
  } glyph_hit_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  logic                 cfg_we;
  logic [CFG_W-1:0]     cfg_wdata;

  // predictor state
  logic [CODE_W-1:0]  glyph_codes [TABLE_SLOTS_DEF];
  logic [ADV_W-1:0]   glyph_adv [TABLE_SLOTS_DEF];
  logic [CARET_W-1:0] caret_pos;
  logic [CFG_W-1:0]   slots_in_use;
  int unsigned        seq_need;
  int unsigned        seq_seen;
  logic [CODE_W-1:0]  seq_acc;
  logic               seq_bad;

  glyph_hit_t         expected_glyphs [$];
  glyph_hit_t         head;
  logic [BYTE_W-1:0]  line_bytes [$];

  bit          table_full;
  bit          rx_hold;
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned words_sent;
  int unsigned glyphs_checked;
  int unsigned table_hits;
  int unsigned strings_done;
  int unsigned mismatches;
  int unsigned odd_count;

  utf8_glyph_lookup_caret i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic int unsigned search_len();
    return (slots_in_use > TABLE_SLOTS_DEF) ? TABLE_SLOTS_DEF : int'(slots_in_use);
  endfunction

  function automatic void lookup_glyph(logic [CODE_W-1:0] cp, logic at_end);
    glyph_hit_t       r;
    logic [CARET_W:0] sum;
    r.codepoint = cp;
    r.found     = 1'b0;
    r.slot      = '0;
    r.caret     = caret_pos;
    r.ends      = at_end;
    for (int i = 0; i < search_len(); i++) begin
      if (glyph_codes[i] == cp) begin
        r.found = 1'b1;
        r.slot  = SLOT_W'(i);
        break;
      end
    end
    expected_glyphs.push_back(r);
    if (r.found) begin
      sum       = {1'b0, caret_pos} + (CARET_W + 1)'(glyph_adv[r.slot]);
      caret_pos = sum[CARET_W] ? CARET_MAX : sum[CARET_W-1:0];
    end
    if (at_end) caret_pos = '0;
    seq_need = 0;
    seq_seen = 0;
    seq_acc  = '0;
    seq_bad  = 1'b0;
  endfunction

  function automatic void decode_text_octet(logic [BYTE_W-1:0] b, logic at_end);
    if (seq_seen == 0) begin
      casez (b)
        8'b0???????: begin
          lookup_glyph({8'h00, b}, at_end);
          return;
        end
        8'b110?????: begin
          seq_need = 2;
          seq_acc  = {11'd0, b[4:0]};
        end
        8'b1110????: begin
          seq_need = 3;
          seq_acc  = {12'd0, b[3:0]};
        end
        8'b11110???: begin
          seq_need = 4;
          seq_acc  = '0;
          seq_bad  = 1'b1;
        end
        default: begin
          lookup_glyph(BAD_CODE, at_end);
          return;
        end
      endcase
      seq_seen = 1;
      if (at_end) lookup_glyph(BAD_CODE, 1'b1);
      return;
    end
    if (b[7:6] != 2'b10) seq_bad = 1'b1;
    seq_acc  = {seq_acc[9:0], b[5:0]};
    seq_seen = seq_seen + 1;
    if (seq_seen >= seq_need) lookup_glyph(seq_bad ? BAD_CODE : seq_acc, at_end);
    else if (at_end) lookup_glyph(BAD_CODE, 1'b1);
  endfunction

  task automatic check_field(string name, logic [CARET_W-1:0] want, logic [CARET_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %h, got %h", glyphs_checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_glyphs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing pending: data %h, last %b", m_tdata, m_tlast);
      end else begin
        head = expected_glyphs.pop_front();
        check_field("codepoint", CARET_W'(head.codepoint), CARET_W'(m_tdata[15:0]));
        check_field("found", CARET_W'(head.found), CARET_W'(m_tdata[16]));
        check_field("glyph_slot", CARET_W'(head.slot), CARET_W'(m_tdata[23:17]));
        check_field("caret", head.caret, m_tdata[47:24]);
        check_field("string_end", CARET_W'(head.ends), CARET_W'(m_tlast));
        glyphs_checked++;
        if (head.found) table_hits++;
        if (head.ends) strings_done++;
      end
    end
  end

  // receiver: picks a new stall pattern for each span of random length
  initial begin : rx_side
    int unsigned mode, span, tick;
    m_tready = 1'b0;
    tick     = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 400);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (rx_hold) m_tready = 1'b0;
        else case (mode)
          0: m_tready = 1'b1;
          1: m_tready = 1'($urandom_range(0, 1));
          2: m_tready = ($urandom_range(0, 7) != 0);
          default: m_tready = (tick % 7) > 2;
        endcase
      end
    end
  end

  // called at a falling edge, returns at a falling edge with tvalid still high
  task automatic send_word(logic kind, logic [SLOT_W-1:0] slot, logic [CODE_W-1:0] cp,
                           logic [ADV_W-1:0] adv, logic [BYTE_W-1:0] octet, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tlast  = last;
    s_tdata  = {1'b0, octet, adv, cp, slot};
    do @(posedge clk); while (!s_tready);
    if (kind == KIND_LOAD) begin
      glyph_codes[slot] = cp;
      glyph_adv[slot]   = adv;
    end else begin
      decode_text_octet(octet, last);
    end
    words_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_text(logic [BYTE_W-1:0] octet, logic last);
    send_word(KIND_TEXT, SLOT_W'($urandom), CODE_W'($urandom), ADV_W'($urandom), octet, last);
  endtask

  task automatic send_entry(logic [SLOT_W-1:0] slot, logic [CODE_W-1:0] cp,
                            logic [ADV_W-1:0] adv);
    send_word(KIND_LOAD, slot, cp, adv, BYTE_W'($urandom), 1'($urandom));
  endtask

  task automatic send_random_entry();
    logic [CODE_W-1:0] cp;
    cp = CODE_W'($urandom);
    // reuse a code already in the table now and then so first-match order matters
    if (table_full && $urandom_range(0, 1)) cp = glyph_codes[$urandom_range(0, TABLE_SLOTS_DEF - 1)];
    send_entry(SLOT_W'($urandom), cp, ADV_W'($urandom));
  endtask

  task automatic send_line(int unsigned load_pct);
    for (int i = 0; i < line_bytes.size(); i++) begin
      if ($urandom_range(0, 99) < load_pct) send_random_entry();
      send_text(line_bytes[i], i == line_bytes.size() - 1);
    end
  endtask

  function automatic void push_utf8(logic [CODE_W-1:0] cp, bit overlong);
    int unsigned len;
    len = (cp < 16'h80) ? 1 : (cp < 16'h800) ? 2 : 3;
    if (overlong && len < 3) len++;
    case (len)
      1: line_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        line_bytes.push_back({3'b110, cp[10:6]});
        line_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        line_bytes.push_back({4'b1110, cp[15:12]});
        line_bytes.push_back({2'b10, cp[11:6]});
        line_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] pick_code(int unsigned lim);
    if (lim == 0) return CODE_W'($urandom);
    return glyph_codes[$urandom_range(0, lim - 1)];
  endfunction

  function automatic void add_random_glyph(int unsigned lim);
    int unsigned      roll, start;
    logic [BYTE_W-1:0] b;
    roll  = $urandom_range(0, 99);
    start = line_bytes.size();
    if (roll < 60) push_utf8(pick_code(lim), 1'b0);
    else if (roll < 68) push_utf8(pick_code(lim), 1'b1);
    else if (roll < 76) push_utf8(CODE_W'($urandom), 1'b0);
    else if (roll < 82) begin
      // stray continuation or a lead byte that no sequence uses
      b = BYTE_W'($urandom_range(8'h80, 8'hBF));
      if ($urandom_range(0, 1)) b = BYTE_W'($urandom_range(8'hF8, 8'hFF));
      line_bytes.push_back(b);
    end else if (roll < 87) begin
      line_bytes.push_back(BYTE_W'($urandom_range(8'hF0, 8'hF7)));
      repeat (3) line_bytes.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
    end else if (roll < 93) begin
      push_utf8(CODE_W'($urandom_range(16'h80, 16'hFFFF)), 1'b0);
      b = BYTE_W'($urandom);
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      line_bytes[$urandom_range(start + 1, line_bytes.size() - 1)] = b;
    end else begin
      line_bytes.push_back(BYTE_W'($urandom));
    end
  endfunction

  function automatic void build_line(int unsigned lim);
    line_bytes.delete();
    repeat ($urandom_range(1, 10)) add_random_glyph(lim);
    // string that stops inside a sequence
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: line_bytes.push_back(BYTE_W'($urandom_range(8'hC0, 8'hDF)));
        1: begin
          line_bytes.push_back(BYTE_W'($urandom_range(8'hE0, 8'hEF)));
          if ($urandom_range(0, 1)) line_bytes.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
        end
        default: begin
          line_bytes.push_back(BYTE_W'($urandom_range(8'hF0, 8'hF7)));
          repeat ($urandom_range(0, 2)) line_bytes.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
        end
      endcase
    end
  endfunction

  // stop sending, let results drain, then allow for a search still running
  task automatic wait_quiet();
    s_tvalid = 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && expected_glyphs.size() != 0; n++) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic write_slots_in_use(logic [CFG_W-1:0] n);
    wait_quiet();
    cfg_wdata = n;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we       = 1'b0;
    slots_in_use = n;
  endtask

  // empty search window: malformed, overlong, four-byte and cut-short forms
  task automatic test_unloaded_decode();
    line_bytes = '{8'h41, 8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hEF, 8'hBF, 8'hBF, 8'h80, 8'hFF,
                   8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE2, 8'h41, 8'h82, 8'hC0, 8'h80, 8'hE0,
                   8'h80};
    send_line(0);
  endtask

  task automatic test_table_fill();
    logic [CODE_W-1:0] cp;
    logic [ADV_W-1:0]  adv;
    for (int s = 0; s < TABLE_SLOTS_DEF; s++) begin
      case ($urandom_range(0, 3))
        0: cp = CODE_W'($urandom_range(0, 16'h7F));
        1: cp = CODE_W'($urandom_range(16'h80, 16'h7FF));
        2: cp = CODE_W'($urandom_range(16'h800, 16'hFFFF));
        default: cp = (s > 0) ? glyph_codes[$urandom_range(0, s - 1)] : 16'h0041;
      endcase
      adv = ADV_W'($urandom);
      if (s == 1) adv = 8'hFF;
      if (s == 2) adv = 8'h00;
      if (s == 3) cp = 16'h0000;
      if (s == 20) cp = glyph_codes[4];
      if (s == TABLE_SLOTS_DEF - 1) cp = BAD_CODE;
      send_entry(SLOT_W'(s), cp, adv);
    end
    table_full = 1'b1;
    write_slots_in_use(CFG_W'(TABLE_SLOTS_DEF));
    line_bytes.delete();
    push_utf8(glyph_codes[0], 1'b0);
    push_utf8(glyph_codes[TABLE_SLOTS_DEF - 1], 1'b0);
    push_utf8(glyph_codes[20], 1'b0);
    push_utf8(glyph_codes[3], 1'b0);
    line_bytes.push_back(8'hBF);
    send_line(0);
    // table write between the two bytes of a sequence
    send_text(8'hC3, 1'b0);
    send_entry(7'd10, 16'h00E9, 8'd7);
    send_text(8'hA9, 1'b1);
  endtask

  task automatic test_random_phases(ref int unsigned odd_count);
    logic [CFG_W-1:0] counts [7];
    int unsigned      sizes [7];
    int unsigned      stop_at;
    odd_count = $urandom_range(2, 127);
    counts = '{8'd128, 8'd1, 8'd64, 8'd255, CFG_W'(odd_count), 8'd0, 8'd128};
    sizes  = '{260, 170, 210, 210, 210, 90, 150};
    for (int p = 0; p < 7; p++) begin
      write_slots_in_use(counts[p]);
      stop_at = words_sent + sizes[p];
      while (words_sent < stop_at) begin
        build_line(search_len());
        send_line(3);
      end
    end
  endtask

  // receiver holds off while words keep coming, so the input must stall
  task automatic test_output_hold();
    int unsigned stop_at;
    fork
      begin
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    stop_at = words_sent + 60;
    while (words_sent < stop_at) begin
      build_line(search_len());
      send_line(3);
    end
  endtask

  // one glyph of maximum advance repeated along a string, then once as a string of its own
  task automatic test_long_string();
    write_slots_in_use(8'd1);
    send_entry(7'd0, 16'h0041, 8'hFF);
    gap_max = 2;
    for (int k = 0; k < LONG_GLYPHS; k++) send_text(8'h41, 1'b0);
    send_text(8'h41, 1'b1);
    send_text(8'h41, 1'b1);
    gap_max = 12;
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = KIND_LOAD;
    s_tlast        = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    caret_pos      = '0;
    slots_in_use   = '0;
    seq_need       = 0;
    seq_seen       = 0;
    seq_acc        = '0;
    seq_bad        = 1'b0;
    table_full     = 1'b0;
    rx_hold        = 1'b0;
    burst_left     = 0;
    gap_max        = 12;
    words_sent     = 0;
    glyphs_checked = 0;
    table_hits     = 0;
    strings_done   = 0;
    mismatches     = 0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_unloaded_decode();
    test_table_fill();
    test_random_phases(odd_count);
    test_output_hold();
    test_long_string();

    wait_quiet();
    if (expected_glyphs.size() != 0) begin
      $display("%0d expected results never arrived", expected_glyphs.size());
      mismatches += expected_glyphs.size();
    end
    $display("sent %0d words; checked %0d results, %0d table hits, %0d strings ended",
             words_sent, glyphs_checked, table_hits, strings_done);
    $display("search lengths 0, 1, 64, %0d, 128 and 255; a long string; %0d-cycle output hold",
             odd_count, HOLD_CYCLES);
    if (mismatches == 0) $display("[utf8_glyph_lookup_caret] OK");
    else $display("[utf8_glyph_lookup_caret] ERROR");
    $finish;
  end

  initial begin
    #80_000_000;
    $display("timeout with %0d results outstanding", expected_glyphs.size());
    $display("[utf8_glyph_lookup_caret] ERROR");
    $finish;
  end

endmodule

FILE: utf8_glyph_lookup_caret.f
+incdir+sv
sv/ugl_pkg.sv
sv/ugl_scan.sv
sv/utf8_glyph_lookup_caret.sv
sv/ugl_checker.sv
bench/tb_utf8_glyph_lookup_caret.sv
